/* src/bfha_pkg.sv */
`timescale 1ns / 1ps
// Package for the best-fit heap allocator: sizes, codes and the block table entry type.
// Has no dependencies; imported by best_fit_heap_allocator.
package bfha_pkg;

    localparam int MAX_BLOCKS     = 64;
    localparam int HEADER_BYTES   = 56;
    localparam int HEAP_MAX_BYTES = 65536;

    localparam int IDX_W = $clog2(MAX_BLOCKS);
    localparam int CNT_W = IDX_W + 1;
    localparam int OFF_W = 16;
    localparam int LEN_W = 17;

    localparam logic [LEN_W-1:0] HEAP_RESET = LEN_W'(4096);
    localparam logic [LEN_W-1:0] HEAP_MIN   = LEN_W'(128);
    localparam logic [LEN_W-1:0] HEAP_TOP   =
        (HEAP_MAX_BYTES < 65536) ? LEN_W'(HEAP_MAX_BYTES) : LEN_W'(65536);
    localparam logic [LEN_W-1:0] ALIGN_MASK = LEN_W'(7);
    localparam logic [LEN_W-1:0] SPLIT_MIN  = LEN_W'(HEADER_BYTES + 8);
    localparam logic [LEN_W-1:0] HDR_LEN    = LEN_W'(HEADER_BYTES);

    localparam logic OP_ALLOC = 1'b0;
    localparam logic OP_FREE  = 1'b1;

    localparam logic [1:0] ST_OK        = 2'd0;
    localparam logic [1:0] ST_NO_SPACE  = 2'd1;
    localparam logic [1:0] ST_ZERO_REQ  = 2'd2;
    localparam logic [1:0] ST_NOT_ALLOC = 2'd3;

    typedef struct packed {
        logic [LEN_W-1:0] len;
        logic [OFF_W-1:0] start;
        logic             free;
    } entry_t;

endpackage

/* src/best_fit_heap_allocator.sv */
`timescale 1ns / 1ps
// Best-fit heap allocator with coalescing; block table held in one synchronous memory.
// Depends on bfha_pkg.
//
// Usage:
//   Requests arrive on the s_ stream: s_tuser carries the opcode (allocate or free),
//   s_tdata the request size and the payload offset to free. Each request produces
//   exactly one transfer on the m_ stream: m_tuser carries the status, m_tdata the
//   payload offset, the block size and the total bytes in use afterwards.
//   The heap size is set through the APB port at address 0; a write reinitializes
//   the table to one free block and clears the byte count. Write it only when idle.
// Operation:
//   One request is handled at a time. The table is walked one entry per cycle through
//   the memory read port, then on a split or merge the entries behind the block move
//   by one read and one write per cycle, and a split then writes the remainder block.
//   A zero-size allocation skips the table walk and goes straight to the result.
// Reset:
//   After aresetn is released the block writes the initial free block of 4096 bytes
//   into entry 0, then accepts requests.
// Stalls:
//   A finished result sits in the output register; the next request is accepted while
//   it waits, and its result is held back until the receiver has taken the previous one.
module best_fit_heap_allocator
    import bfha_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    // APB configuration port
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    // Request stream
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,   // [15:0] request_bytes, [31:16] payload_offset
    input  logic        s_tuser,   // [0] opcode
    // Result stream
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [55:0] m_tdata,   // [15:0] result_offset, [32:16] block_bytes,
                                   // [49:33] used_bytes, [55:50] zero
    output logic [1:0]  m_tuser    // [1:0] status
);

    localparam logic [2:0] S_INIT   = 3'd0;
    localparam logic [2:0] S_IDLE   = 3'd1;
    localparam logic [2:0] S_SCAN   = 3'd2;
    localparam logic [2:0] S_DECIDE = 3'd3;
    localparam logic [2:0] S_SHIFT  = 3'd4;
    localparam logic [2:0] S_TAIL   = 3'd5;
    localparam logic [2:0] S_DONE   = 3'd6;

    // Block table memory.
    entry_t mem [MAX_BLOCKS];
    entry_t rdata_reg;
    logic [IDX_W-1:0] rd_addr;
    logic             wr_en;
    logic [IDX_W-1:0] wr_addr;
    entry_t           wr_data;

    logic [2:0]       state_reg;
    logic [LEN_W-1:0] heap_reg;
    logic [CNT_W-1:0] count_reg;
    logic [LEN_W-1:0] used_reg;

    // Latched request.
    logic             op_reg;
    logic [LEN_W-1:0] need_reg;
    logic [OFF_W-1:0] poff_reg;

    // Scan pipeline.
    logic [CNT_W-1:0] scan_addr_reg;
    logic             rv_reg;
    logic [IDX_W-1:0] ri_reg;
    entry_t           last_reg;
    logic             found_reg;
    logic [IDX_W-1:0] hit_idx_reg;
    entry_t           hit_reg;
    logic             pf_reg;
    entry_t           prev_reg;
    logic             nf_reg;
    logic [LEN_W-1:0] nlen_reg;

    // Shift engine.
    logic             sh_up_reg;
    logic [1:0]       sh_amt_reg;
    logic [CNT_W-1:0] sh_cnt_reg;
    logic [IDX_W-1:0] sh_src_reg;
    logic             pv_reg;
    logic [IDX_W-1:0] pdst_reg;

    // Split tail entry and result.
    logic             split_reg;
    logic [IDX_W-1:0] tail_addr_reg;
    entry_t           tail_reg;
    logic [CNT_W-1:0] count_new_reg;
    logic [LEN_W-1:0] used_new_reg;
    logic [1:0]       status_reg;
    logic [OFF_W-1:0] roff_reg;
    logic [LEN_W-1:0] bbytes_reg;

    logic cfg_wr;
    logic [LEN_W-1:0] cfg_val;

    assign pready   = 1'b1;
    assign cfg_wr   = psel && penable && pwrite && !paddr[2];
    assign prdata   = paddr[2] ? 32'd0 : {{(32-LEN_W){1'b0}}, heap_reg};
    // A register write in the idle state takes the cycle, so no request is taken then.
    assign s_tready = (state_reg == S_IDLE) && !cfg_wr;

    always_comb begin
        if (pwdata < {{(32-LEN_W){1'b0}}, HEAP_MIN}) begin
            cfg_val = HEAP_MIN;
        end else if (pwdata > {{(32-LEN_W){1'b0}}, HEAP_TOP}) begin
            cfg_val = HEAP_TOP;
        end else begin
            cfg_val = pwdata[LEN_W-1:0];
        end
    end

    // Head write values computed from the scan results.
    logic             is_split;
    logic [LEN_W-1:0] merged_len;
    logic [CNT_W-1:0] free_src;
    always_comb begin
        is_split   = (hit_reg.len > need_reg + SPLIT_MIN) &&
                     (count_reg < CNT_W'(MAX_BLOCKS));
        merged_len = hit_reg.len + (pf_reg ? prev_reg.len : '0) + (nf_reg ? nlen_reg : '0);
        free_src   = CNT_W'(hit_idx_reg) + CNT_W'(1) + CNT_W'(nf_reg);
    end

    // Memory port selection.
    always_comb begin
        rd_addr = (state_reg == S_SHIFT) ? sh_src_reg : scan_addr_reg[IDX_W-1:0];
        wr_en   = 1'b0;
        wr_addr = '0;
        wr_data = '0;
        unique case (state_reg)
            S_INIT: begin
                wr_en   = 1'b1;
                wr_data = '{len: cfg_wr ? cfg_val : heap_reg, start: '0, free: 1'b1};
            end
            S_IDLE: begin
                wr_en   = cfg_wr;
                wr_data = '{len: cfg_val, start: '0, free: 1'b1};
            end
            S_DECIDE: begin
                if (found_reg) begin
                    wr_en = 1'b1;
                    if (op_reg == OP_ALLOC) begin
                        wr_addr = hit_idx_reg;
                        wr_data = '{len: is_split ? need_reg : hit_reg.len,
                                    start: hit_reg.start, free: 1'b0};
                    end else begin
                        wr_addr = pf_reg ? hit_idx_reg - IDX_W'(1) : hit_idx_reg;
                        wr_data = '{len: merged_len,
                                    start: pf_reg ? prev_reg.start : hit_reg.start,
                                    free: 1'b1};
                    end
                end
            end
            S_SHIFT: begin
                wr_en   = pv_reg;
                wr_addr = pdst_reg;
                wr_data = rdata_reg;
            end
            S_TAIL: begin
                wr_en   = 1'b1;
                wr_addr = tail_addr_reg;
                wr_data = tail_reg;
            end
            S_SCAN, S_DONE: begin
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        rdata_reg <= mem[rd_addr];
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_INIT;
            heap_reg  <= HEAP_RESET;
            count_reg <= CNT_W'(1);
            used_reg  <= '0;
            m_tvalid  <= 1'b0;
            rv_reg    <= 1'b0;
            pv_reg    <= 1'b0;
        end else begin
            // In S_DONE the output register is reloaded below instead.
            if (m_tvalid && m_tready && state_reg != S_DONE) begin
                m_tvalid <= 1'b0;
            end
            unique case (state_reg)
                S_INIT: begin
                    if (cfg_wr) begin
                        heap_reg <= cfg_val;
                    end
                    state_reg <= S_IDLE;
                end
                S_IDLE: begin
                    if (cfg_wr) begin
                        heap_reg  <= cfg_val;
                        count_reg <= CNT_W'(1);
                        used_reg  <= '0;
                    end else if (s_tvalid) begin
                        op_reg        <= s_tuser;
                        need_reg      <= ({1'b0, s_tdata[15:0]} + HDR_LEN + ALIGN_MASK)
                                         & ~ALIGN_MASK;
                        poff_reg      <= s_tdata[31:16];
                        scan_addr_reg <= '0;
                        rv_reg        <= 1'b0;
                        found_reg     <= 1'b0;
                        pf_reg        <= 1'b0;
                        nf_reg        <= 1'b0;
                        last_reg      <= '0;
                        roff_reg      <= '0;
                        bbytes_reg    <= '0;
                        split_reg     <= 1'b0;
                        sh_cnt_reg    <= '0;
                        used_new_reg  <= used_reg;
                        count_new_reg <= count_reg;
                        if (s_tuser == OP_ALLOC && s_tdata[15:0] == 16'd0) begin
                            status_reg <= ST_ZERO_REQ;
                            state_reg  <= S_DONE;
                        end else begin
                            status_reg <= ST_OK;
                            state_reg  <= S_SCAN;
                        end
                    end
                end
                S_SCAN: begin
                    // The read address runs one entry ahead, so the flag drops by
                    // itself once the last live entry has been processed.
                    rv_reg <= scan_addr_reg < count_reg;
                    ri_reg <= scan_addr_reg[IDX_W-1:0];
                    if (scan_addr_reg < count_reg) begin
                        scan_addr_reg <= scan_addr_reg + CNT_W'(1);
                    end
                    if (rv_reg) begin
                        last_reg <= rdata_reg;
                        if (op_reg == OP_ALLOC) begin
                            if (rdata_reg.free && rdata_reg.len >= need_reg &&
                                (!found_reg || rdata_reg.len < hit_reg.len)) begin
                                found_reg   <= 1'b1;
                                hit_idx_reg <= ri_reg;
                                hit_reg     <= rdata_reg;
                            end
                        end else begin
                            if (!found_reg && !rdata_reg.free &&
                                ({1'b0, rdata_reg.start} + HDR_LEN) == {1'b0, poff_reg}) begin
                                found_reg   <= 1'b1;
                                hit_idx_reg <= ri_reg;
                                hit_reg     <= rdata_reg;
                                pf_reg      <= (ri_reg != '0) && last_reg.free;
                                prev_reg    <= last_reg;
                            end
                            if (found_reg && ri_reg == hit_idx_reg + IDX_W'(1)) begin
                                nf_reg   <= rdata_reg.free;
                                nlen_reg <= rdata_reg.len;
                            end
                        end
                        if (CNT_W'(ri_reg) == count_reg - CNT_W'(1)) begin
                            state_reg <= S_DECIDE;
                        end
                    end
                end
                S_DECIDE: begin
                    pv_reg <= 1'b0;
                    if (!found_reg) begin
                        status_reg <= (op_reg == OP_ALLOC) ? ST_NO_SPACE : ST_NOT_ALLOC;
                        state_reg  <= S_DONE;
                    end else if (op_reg == OP_ALLOC) begin
                        roff_reg      <= hit_reg.start + OFF_W'(HEADER_BYTES);
                        bbytes_reg    <= is_split ? need_reg : hit_reg.len;
                        used_new_reg  <= used_reg + (is_split ? need_reg : hit_reg.len);
                        split_reg     <= is_split;
                        tail_addr_reg <= hit_idx_reg + IDX_W'(1);
                        tail_reg      <= '{len: hit_reg.len - need_reg,
                                           start: hit_reg.start + need_reg[OFF_W-1:0],
                                           free: 1'b1};
                        sh_up_reg     <= 1'b1;
                        sh_amt_reg    <= 2'd1;
                        sh_src_reg    <= IDX_W'(count_reg - CNT_W'(1));
                        sh_cnt_reg    <= count_reg - CNT_W'(1) - CNT_W'(hit_idx_reg);
                        if (is_split) begin
                            count_new_reg <= count_reg + CNT_W'(1);
                            state_reg     <= S_SHIFT;
                        end else begin
                            state_reg <= S_DONE;
                        end
                    end else begin
                        bbytes_reg    <= hit_reg.len;
                        used_new_reg  <= used_reg - hit_reg.len;
                        sh_up_reg     <= 1'b0;
                        sh_amt_reg    <= {1'b0, pf_reg} + {1'b0, nf_reg};
                        sh_src_reg    <= free_src[IDX_W-1:0];
                        sh_cnt_reg    <= count_reg - free_src;
                        count_new_reg <= count_reg - CNT_W'(pf_reg) - CNT_W'(nf_reg);
                        state_reg     <= (pf_reg || nf_reg) ? S_SHIFT : S_DONE;
                    end
                end
                S_SHIFT: begin
                    pv_reg <= sh_cnt_reg != '0;
                    if (sh_cnt_reg != '0) begin
                        sh_cnt_reg <= sh_cnt_reg - CNT_W'(1);
                        if (sh_up_reg) begin
                            pdst_reg   <= sh_src_reg + IDX_W'(1);
                            sh_src_reg <= sh_src_reg - IDX_W'(1);
                        end else begin
                            pdst_reg   <= sh_src_reg - IDX_W'(sh_amt_reg);
                            sh_src_reg <= sh_src_reg + IDX_W'(1);
                        end
                    end else if (!pv_reg) begin
                        state_reg <= split_reg ? S_TAIL : S_DONE;
                    end
                end
                S_TAIL: begin
                    state_reg <= S_DONE;
                end
                S_DONE: begin
                    if (!m_tvalid || m_tready) begin
                        m_tvalid  <= 1'b1;
                        m_tuser   <= status_reg;
                        m_tdata   <= {6'd0, used_new_reg, bbytes_reg, roff_reg};
                        used_reg  <= used_new_reg;
                        count_reg <= count_new_reg;
                        state_reg <= S_IDLE;
                    end
                end
                default: begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    // The table never empties and never overflows.
    assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg != '0 && count_reg <= CNT_W'(MAX_BLOCKS))
        else $error("block count out of range");

    // Allocated bytes never exceed the heap.
    assert property (@(posedge aclk) disable iff (!aresetn)
        used_reg <= heap_reg)
        else $error("bytes in use exceed heap size");

    // Shift writes stay inside the live part of the table.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_SHIFT && pv_reg) |-> CNT_W'(pdst_reg) <= count_reg)
        else $error("shift write beyond table");

    // A result is only loaded once the previous one has been taken.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tready) |=> $stable(m_tdata))
        else $error("pending result overwritten");

endmodule
